/* src/nma_pkg.sv */
// ---------------------------------------------------------------------------
// nma_pkg: shared types and constants for the neighbour mask autotiler
// Transfer payloads, register indexes and the control bundle that drives
// the row delay lines.
// ---------------------------------------------------------------------------
package nma_pkg;

   // Configuration register indexes
   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROW_WIDTH   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MATCH_VALUE = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TABLE_WORD0 = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TABLE_WORD1 = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TABLE_WORD2 = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TABLE_WORD3 = 3'd5;

   localparam int CSR_DATA_BITS = 64;
   localparam int FIELD_BITS    = 16;
   localparam int WIDTH_BITS    = 6;
   localparam int TABLE_WORDS   = 4;

   // Register reset values
   localparam logic [WIDTH_BITS-1:0] ROW_WIDTH_RESET = 6'd32;

   // Input transfer payload
   typedef struct packed {
      logic signed [FIELD_BITS-1:0] tile_in;
      logic                         last_tile;
   } req_data_type;

   // Result transfer payload
   typedef struct packed {
      logic signed [FIELD_BITS-1:0] tile_out;
      logic                         is_last;
   } rsp_data_type;

   // Control for a row delay line: shift strobe and active row length
   typedef struct packed {
      logic                  shift;
      logic [WIDTH_BITS-1:0] width;
   } line_ctrl_type;

endpackage

/* src/nma_cell.sv */
// ---------------------------------------------------------------------------
// nma_cell: one tile slot of a row delay line
// On a shift the slot loads either its upstream neighbor or, when it is
// the head of the active row length, the new tile.
// ---------------------------------------------------------------------------
module nma_cell #(
   parameter int WIDTH = 16
) (
   input  logic             clock,
   input  logic             shift,
   input  logic             head,
   input  logic [WIDTH-1:0] shift_data,
   input  logic [WIDTH-1:0] load_data,
   output logic [WIDTH-1:0] cell_q
);

   logic [WIDTH-1:0] q_ff;
   logic [WIDTH-1:0] q_in;

   // Pick upstream or injected tile
   always_comb begin
      q_in = head ? load_data : shift_data;
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         q_ff <= q_in;
      end
   end

   assign cell_q = q_ff;

endmodule

/* src/nma_line.sv */
// ---------------------------------------------------------------------------
// nma_line: programmable-length row delay line
// A chain of cells; the new tile enters at the cell that sits row-width
// slots from the tail, so a tile reaches the tail after one row of shifts.
// ---------------------------------------------------------------------------
module nma_line #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 16
) (
   input  logic                  clock,
   input  nma_pkg::line_ctrl_type ctrl,
   input  logic [WIDTH-1:0]      line_data,
   output logic [WIDTH-1:0]      tail,
   output logic [WIDTH-1:0]      tail_prev
);
   import nma_pkg::*;

   logic [WIDTH-1:0] slot_q [DEPTH];

   // Cell k is the head when the row length equals its distance to the tail
   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      logic             head;
      logic [WIDTH-1:0] upstream;

      assign head = (ctrl.width == WIDTH_BITS'(DEPTH - k));
      if (k == 0) begin : g_first
         assign upstream = line_data;
      end else begin : g_rest
         assign upstream = slot_q[k-1];
      end

      nma_cell #(
         .WIDTH(WIDTH)
      ) u_cell (
         .clock     (clock),
         .shift     (ctrl.shift),
         .head      (head),
         .shift_data(upstream),
         .load_data (line_data),
         .cell_q    (slot_q[k])
      );
   end

   // Fixed taps at the tail
   assign tail = slot_q[DEPTH-1];
   if (DEPTH >= 2) begin : g_prev
      assign tail_prev = slot_q[DEPTH-2];
   end else begin : g_prev_single
      assign tail_prev = slot_q[DEPTH-1];
   end

endmodule

/* src/neighbour_mask_autotile.sv */
// ---------------------------------------------------------------------------
// neighbour_mask_autotile: four-neighbour bitmask autotiler
// Streams a tile map in raster order and replaces matching tiles by table
// entries picked from the top/right/bottom/left match code.
// ---------------------------------------------------------------------------
// While a map streams in, the block takes one tile per cycle when its output
// register is free or being taken, and returns results one row behind the
// input. The tile marked last is followed by a flush as long as the effective
// row length, during which the input is stalled and filler tiles reading
// as -1 push the two row delay lines forward so the held rows drain; a map
// of one row therefore returns all its results during the flush. A tile may
// be taken in the same cycle as the previous result when the output register
// is free or being taken. Writing row_width restarts the map at the first row.
module neighbour_mask_autotile #(
   parameter int MAX_ROW_WIDTH = 32,
   parameter int TILE_BITS     = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  nma_pkg::req_data_type                 req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output nma_pkg::rsp_data_type                 rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [nma_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [nma_pkg::CSR_DATA_BITS-1:0]     csr_data
);
   import nma_pkg::*;

   localparam logic [WIDTH_BITS-1:0] MaxWidth = WIDTH_BITS'(MAX_ROW_WIDTH);
   localparam logic [TILE_BITS-1:0]  Outside  = '1;

   // Configuration registers
   logic [WIDTH_BITS-1:0]    row_width_ff;
   logic signed [FIELD_BITS-1:0] match_ff;
   logic [CSR_DATA_BITS-1:0] table_ff [TABLE_WORDS];

   // Position and flush control
   logic [WIDTH_BITS-1:0] col_ff,   col_in;
   logic [1:0]            phase_ff, phase_in;
   logic                  flush_ff, flush_in;
   logic [WIDTH_BITS-1:0] flush_count_ff, flush_count_in;

   // Output register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_data_type rsp_data_ff,  rsp_data_in;

   logic                  width_write;
   logic [WIDTH_BITS-1:0] eff_width;
   logic                  can_load;
   logic                  step;
   logic                  emit;
   logic [TILE_BITS-1:0]  step_tile;
   logic [TILE_BITS-1:0]  match_w;
   logic [TILE_BITS-1:0]  center, right_n, left_n, top_n;
   logic [TILE_BITS-1:0]  a_tail, a_tail_prev, b_tail;
   logic [TILE_BITS-1:0]  left_ff;
   logic [3:0]            code;
   logic [FIELD_BITS-1:0] entry;
   logic [TILE_BITS-1:0]  result;
   line_ctrl_type         line_ctrl;

   assign csr_ready   = 1'b1;
   assign width_write = csr_valid && (csr_index == CSR_ROW_WIDTH);

   // Row length after clamping out-of-range values
   always_comb begin
      if (row_width_ff == '0) begin
         eff_width = WIDTH_BITS'(1);
      end else if (row_width_ff > MaxWidth) begin
         eff_width = MaxWidth;
      end else begin
         eff_width = row_width_ff;
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= ROW_WIDTH_RESET;
         match_ff     <= '0;
         for (int i = 0; i < TABLE_WORDS; i++) begin
            table_ff[i] <= '0;
         end
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ROW_WIDTH:   row_width_ff <= csr_data[WIDTH_BITS-1:0];
            CSR_MATCH_VALUE: match_ff     <= csr_data[FIELD_BITS-1:0];
            CSR_TABLE_WORD0: table_ff[0]  <= csr_data;
            CSR_TABLE_WORD1: table_ff[1]  <= csr_data;
            CSR_TABLE_WORD2: table_ff[2]  <= csr_data;
            CSR_TABLE_WORD3: table_ff[3]  <= csr_data;
            default: ;
         endcase
      end
   end

   // Step: a new tile or a filler tile of the flush
   assign can_load  = !rsp_valid_ff || !rsp_stall;
   assign step      = can_load && (flush_ff || req_valid);
   assign req_stall = flush_ff || !can_load;
   assign step_tile = flush_ff ? Outside : TILE_BITS'(req_data.tile_in);
   assign emit      = step && (phase_ff != 2'd0);

   assign line_ctrl.shift = step;
   assign line_ctrl.width = eff_width;

   // Current row line and the line one row further back
   nma_line #(
      .DEPTH(MAX_ROW_WIDTH),
      .WIDTH(TILE_BITS)
   ) u_line_a (
      .clock    (clock),
      .ctrl     (line_ctrl),
      .line_data(step_tile),
      .tail     (a_tail),
      .tail_prev(a_tail_prev)
   );

   nma_line #(
      .DEPTH(MAX_ROW_WIDTH),
      .WIDTH(TILE_BITS)
   ) u_line_b (
      .clock    (clock),
      .ctrl     (line_ctrl),
      .line_data(a_tail),
      .tail     (b_tail),
      .tail_prev()
   );

   // Left neighbor: the tile that just left the current row line
   always_ff @(posedge clock) begin
      if (step) begin
         left_ff <= a_tail;
      end
   end

   // Neighbors with map-edge handling
   assign match_w = TILE_BITS'(match_ff);
   assign center  = a_tail;
   assign top_n   = (phase_ff == 2'd2) ? b_tail : Outside;
   assign right_n = (col_ff != eff_width - WIDTH_BITS'(1)) ? a_tail_prev : Outside;
   assign left_n  = (col_ff != '0) ? left_ff : Outside;

   // Match code and table lookup
   always_comb begin
      code[0] = (top_n == match_w);
      code[1] = (right_n == match_w);
      code[2] = (step_tile == match_w);
      code[3] = (left_n == match_w);
      entry   = table_ff[code[3:2]][{code[1:0], 4'd0} +: FIELD_BITS];
      if (center == match_w) begin
         result = TILE_BITS'(signed'(entry));
      end else begin
         result = center;
      end
   end

   // Column, row phase and flush tracking
   always_comb begin
      col_in         = col_ff;
      phase_in       = phase_ff;
      flush_in       = flush_ff;
      flush_count_in = flush_count_ff;
      if (width_write) begin
         col_in   = '0;
         phase_in = '0;
         flush_in = 1'b0;
      end else if (step) begin
         if (col_ff == eff_width - WIDTH_BITS'(1)) begin
            col_in = '0;
            if (phase_ff != 2'd2) begin
               phase_in = phase_ff + 2'd1;
            end
         end else begin
            col_in = col_ff + WIDTH_BITS'(1);
         end
         if (flush_ff) begin
            flush_count_in = flush_count_ff - WIDTH_BITS'(1);
            if (flush_count_ff == WIDTH_BITS'(1)) begin
               col_in   = '0;
               phase_in = '0;
               flush_in = 1'b0;
            end
         end else if (req_data.last_tile) begin
            flush_in       = 1'b1;
            flush_count_in = eff_width;
         end
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in         = 1'b1;
         rsp_data_in.tile_out = FIELD_BITS'(result);
         rsp_data_in.is_last  = flush_ff && (flush_count_ff == WIDTH_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff         <= '0;
         phase_ff       <= '0;
         flush_ff       <= 1'b0;
         flush_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         col_ff         <= col_in;
         phase_ff       <= phase_in;
         flush_ff       <= flush_in;
         flush_count_ff <= flush_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* sim/tb_top.sv */
// ---------------------------------------------------------------------------
// tb_top: testbench for the neighbour mask autotiler
// Streams tile maps through the block and checks every autotiled tile
// against an in-bench prediction of the four-neighbour match code.
// Covers row width clamping, short final rows, single-row maps, mid-map
// restarts, and input/output idling including a long output hold-off.
// ---------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import nma_pkg::*;

   localparam int          MAX_W         = 32;
   localparam int          SETTLE_CYCLES = 2 * MAX_W + 16;
   localparam int          HOLD_CYCLES   = 200;
   localparam int          CYCLE_LIMIT   = 200000;
   localparam logic [15:0] OFF_MAP       = 16'hFFFF;

   // indexes past the register list, writes there are ignored
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_B = 3'd7;

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   req_data_type              req_data  = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_data_type              rsp_data;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data  = '0;

   // stimulus and expected results
   req_data_type tiles_to_send[$];
   rsp_data_type tiles_due[$];
   int unsigned  tiles_queued   = 0;
   int unsigned  tiles_taken    = 0;
   int unsigned  mismatches     = 0;
   int unsigned  cycle_count    = 0;
   int unsigned  send_gap_pct   = 0;
   int unsigned  recv_stall_pct = 0;
   int unsigned  hold_left      = 0;
   logic         hold_start     = 1'b0;

   // predicted block state and registers
   logic [15:0]           row_mem [2][MAX_W];
   int unsigned           col_next;
   int unsigned           row_stage;
   int unsigned           row_sel;
   logic [WIDTH_BITS-1:0] width_reg;
   logic [15:0]           match_reg;
   logic [63:0]           table_reg [TABLE_WORDS];

   neighbour_mask_autotile dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // replacement for one tile given its four neighbours
   function automatic logic [15:0] autotile_pick(input logic [15:0] self, top, right,
                                                 bottom, left);
      logic [3:0] code;
      if (self != match_reg) return self;
      code = {left == match_reg, bottom == match_reg, right == match_reg, top == match_reg};
      return table_reg[code[3:2]][16 * code[1:0] +: 16];
   endfunction

   function automatic void add_due(input logic [15:0] value);
      rsp_data_type res;
      res.tile_out = value;
      res.is_last  = 1'b0;
      tiles_due.push_back(res);
   endfunction

   // advance the predicted state by one accepted tile
   task automatic predict_autotile(input req_data_type item);
      int unsigned  w, x, cur, prv, c;
      logic [15:0]  v, t, r, l;
      rsp_data_type res;
      w   = (width_reg == 0) ? 1 : (width_reg > MAX_W ? MAX_W : width_reg);
      x   = (col_next >= w) ? 0 : col_next;
      cur = row_sel;
      prv = cur ^ 1;
      v   = item.tile_in;
      // tile above the current one now has its bottom neighbour
      if (row_stage >= 1) begin
         t = (row_stage >= 2) ? row_mem[cur][x] : OFF_MAP;
         r = (x + 1 < w) ? row_mem[prv][x + 1] : OFF_MAP;
         l = (x > 0) ? row_mem[prv][x - 1] : OFF_MAP;
         add_due(autotile_pick(row_mem[prv][x], t, r, v, l));
      end
      row_mem[cur][x] = v;
      if (!item.last_tile) begin
         x++;
         if (x >= w) begin
            x       = 0;
            row_sel = prv;
            if (row_stage < 2) row_stage++;
         end
         col_next = x;
      end else begin
         // flush: rest of the previous row, then the final row
         if (row_stage >= 1) begin
            for (c = x + 1; c < w; c++) begin
               t = (row_stage >= 2) ? row_mem[cur][c] : OFF_MAP;
               r = (c + 1 < w) ? row_mem[prv][c + 1] : OFF_MAP;
               add_due(autotile_pick(row_mem[prv][c], t, r, OFF_MAP, row_mem[prv][c - 1]));
            end
         end
         for (c = 0; c <= x; c++) begin
            t = (row_stage >= 1) ? row_mem[prv][c] : OFF_MAP;
            r = (c + 1 <= x) ? row_mem[cur][c + 1] : OFF_MAP;
            l = (c > 0) ? row_mem[cur][c - 1] : OFF_MAP;
            add_due(autotile_pick(row_mem[cur][c], t, r, OFF_MAP, l));
         end
         res         = tiles_due.pop_back();
         res.is_last = 1'b1;
         tiles_due.push_back(res);
         col_next  = 0;
         row_stage = 0;
         row_sel   = 0;
      end
   endtask

   // register write, called at a rising edge while the block is idle
   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] reg_index,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= reg_index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (reg_index)
         CSR_ROW_WIDTH: begin
            width_reg = value[WIDTH_BITS-1:0];
            col_next  = 0;
            row_stage = 0;
            row_sel   = 0;
         end
         CSR_MATCH_VALUE: match_reg = value[15:0];
         CSR_TABLE_WORD0: table_reg[0] = value;
         CSR_TABLE_WORD1: table_reg[1] = value;
         CSR_TABLE_WORD2: table_reg[2] = value;
         CSR_TABLE_WORD3: table_reg[3] = value;
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic push_tile(input logic [15:0] value, input bit last);
      req_data_type item;
      item.tile_in   = value;
      item.last_tile = last;
      tiles_to_send.push_back(item);
      tiles_queued++;
   endtask

   // wait until every queued tile is taken and every result has come back
   task automatic wait_quiet(input int unsigned settle);
      do @(posedge clock); while (tiles_taken != tiles_queued || tiles_due.size() != 0);
      repeat (settle) @(posedge clock);
   endtask

   // one map of random tiles, biased toward the match value
   task automatic send_map(input int unsigned count, input int unsigned pause_at);
      logic [15:0] tile;
      for (int unsigned i = 0; i < count; i++) begin
         if (i == pause_at && i != 0) wait_quiet(0);
         case ($urandom_range(3))
            0, 1: tile = match_reg;
            2: tile = 16'($urandom);
            default: begin
               case ($urandom_range(3))
                  0: tile = 16'hFFFF;
                  1: tile = 16'h8000;
                  2: tile = 16'h7FFF;
                  default: tile = match_reg ^ 16'h0001;
               endcase
            end
         endcase
         push_tile(tile, i == count - 1);
      end
   endtask

   // input driver: offers queued tiles, predicts each accepted transfer
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_autotile(req_data);
            tiles_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (tiles_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
               req_valid <= 1'b1;
               req_data  <= tiles_to_send.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long output hold-off, counted down in cycles
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_start) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // result monitor: checks each accepted transfer against the oldest due tile
   always @(posedge clock) begin
      rsp_data_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (tiles_due.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected result: tile_out %0d is_last %0b",
                           rsp_data.tile_out, rsp_data.is_last);
               mismatches++;
            end else begin
               want = tiles_due.pop_front();
               if (rsp_data.tile_out != want.tile_out || rsp_data.is_last != want.is_last) begin
                  if (mismatches < 10)
                     $display("mismatch: tile_out exp %0d got %0d, is_last exp %0b got %0b",
                              want.tile_out, rsp_data.tile_out, want.is_last,
                              rsp_data.is_last);
                  mismatches++;
               end
            end
         end
         rsp_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** neighbour_mask_autotile: FAILED **");
         $finish;
      end
   end

   initial begin
      logic [63:0]           word;
      logic [WIDTH_BITS-1:0] width;
      int unsigned           w_eff, budget, count, span, pause_at;

      // predicted reset state
      foreach (row_mem[i, j]) row_mem[i][j] = '0;
      col_next  = 0;
      row_stage = 0;
      row_sel   = 0;
      width_reg = ROW_WIDTH_RESET;
      match_reg = '0;
      foreach (table_reg[i]) table_reg[i] = '0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: distinct entry per code so every code shows
      for (int k = 0; k < TABLE_WORDS; k++) begin
         for (int j = 0; j < 4; j++) word[16 * j +: 16] = 16'hA000 + 16'(4 * k + j);
         write_csr(CSR_TABLE_WORD0 + 3'(k), word);
      end
      write_csr(CSR_ROW_WIDTH, 64'd3);
      write_csr(CSR_MATCH_VALUE, 64'd0);

      // 3x3 map with extreme non-matching tiles
      push_tile(16'h0000, 1'b0); push_tile(16'h8000, 1'b0); push_tile(16'h0000, 1'b0);
      push_tile(16'h0000, 1'b0); push_tile(16'h0000, 1'b0); push_tile(16'h0000, 1'b0);
      push_tile(16'h7FFF, 1'b0); push_tile(16'h0000, 1'b0); push_tile(16'h0000, 1'b1);
      wait_quiet(SETTLE_CYCLES);

      // short final row, sender pauses mid-map until drained
      push_tile(16'h0000, 1'b0); push_tile(16'h0000, 1'b0); push_tile(16'h0000, 1'b0);
      push_tile(16'h0000, 1'b0);
      wait_quiet(0);
      push_tile(16'h0000, 1'b1);
      wait_quiet(SETTLE_CYCLES);

      // zero row width acts as one tile per row
      write_csr(CSR_ROW_WIDTH, 64'd0);
      write_csr(CSR_MATCH_VALUE, 64'h7FFF);
      push_tile(16'h7FFF, 1'b0); push_tile(16'h7FFF, 1'b1);
      wait_quiet(SETTLE_CYCLES);

      // oversize width clamps; single-row maps; match on the off-map value
      write_csr(CSR_ROW_WIDTH, 64'd63);
      write_csr(CSR_MATCH_VALUE, 64'hFFFF_FFFF_FFFF_FFFF);
      push_tile(16'hFFFF, 1'b0); push_tile(16'hFFFF, 1'b0); push_tile(16'h0005, 1'b1);
      push_tile(16'hFFFF, 1'b1);
      wait_quiet(SETTLE_CYCLES);

      // ignored indexes, then a row width write in the middle of a map
      write_csr(CSR_SPARE_A, {$urandom, $urandom});
      write_csr(CSR_SPARE_B, {$urandom, $urandom});
      write_csr(CSR_ROW_WIDTH, 64'd2);
      write_csr(CSR_MATCH_VALUE, 64'd0);
      push_tile(16'h0000, 1'b0); push_tile(16'h0000, 1'b0); push_tile(16'h0000, 1'b0);
      wait_quiet(SETTLE_CYCLES);
      write_csr(CSR_ROW_WIDTH, 64'd2);
      push_tile(16'h0000, 1'b0); push_tile(16'h0000, 1'b0); push_tile(16'h0000, 1'b0);
      push_tile(16'h0000, 1'b1);

      // random maps across idling phases
      for (int p = 0; p < 4; p++) begin
         for (int g = 0; g < 2; g++) begin
            wait_quiet(SETTLE_CYCLES);
            case (p)
               0: begin send_gap_pct <= 0;  recv_stall_pct <= 0;  end
               1: begin send_gap_pct <= 60; recv_stall_pct <= 0;  end
               2: begin send_gap_pct <= 0;  recv_stall_pct <= 60; end
               default: begin send_gap_pct <= 35; recv_stall_pct <= 35; end
            endcase

            case ($urandom_range(9))
               0: width = 6'd0;
               1: width = 6'd32;
               2: width = 6'd63;
               default: width = 6'($urandom_range(12, 1));
            endcase
            if (p == 0 && g == 0) width = 6'd32;
            w_eff = (width == 0) ? 1 : (width > MAX_W ? MAX_W : width);
            write_csr(CSR_ROW_WIDTH, 64'(width));
            case ($urandom_range(5))
               0: write_csr(CSR_MATCH_VALUE, 64'h8000);
               1: write_csr(CSR_MATCH_VALUE, 64'h7FFF);
               2: write_csr(CSR_MATCH_VALUE, 64'hFFFF);
               3: write_csr(CSR_MATCH_VALUE, 64'h0000);
               default: write_csr(CSR_MATCH_VALUE, {$urandom, $urandom});
            endcase
            for (int k = 0; k < TABLE_WORDS; k++) begin
               case ($urandom_range(5))
                  0: word = '0;
                  1: word = '1;
                  default: word = {$urandom, $urandom};
               endcase
               write_csr(CSR_TABLE_WORD0 + 3'(k), word);
            end
            if ($urandom_range(3) == 0) write_csr(CSR_SPARE_A, {$urandom, $urandom});

            if (p == 0 && g == 0) begin
               // full row plus a few tiles: the largest flush, with output held
               // off so the block backs up and stalls its input while the
               // sender keeps offering tiles
               hold_start <= 1'b1;
               send_map(MAX_W + 8, 0);
               @(posedge clock);
               hold_start <= 1'b0;
            end else begin
               budget = 12;
               while (budget > 0) begin
                  span     = (w_eff * 3 > 40) ? 40 : w_eff * 3;
                  if (span > budget) span = budget;
                  count    = $urandom_range(span, 1);
                  pause_at = ($urandom_range(7) == 0) ? $urandom_range(count - 1, 0) : 0;
                  send_map(count, pause_at);
                  budget = (budget > count) ? budget - count : 0;
               end
            end
         end
      end

      wait_quiet(SETTLE_CYCLES);
      if (mismatches == 0 && tiles_due.size() == 0) begin
         $display("** neighbour_mask_autotile: PASSED **");
      end else begin
         $display("** neighbour_mask_autotile: FAILED **");
      end
      $finish;
   end

endmodule
